[src/stream_substring_replace_assert.svh]
// Assertion macros used by the port-level checker of the substring replace block.
`ifndef STREAM_SUBSTRING_REPLACE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ssr_pkg.sv]
// Types and constants for the streaming substring replace block.
`timescale 1ns / 1ps
package ssr_pkg;

  localparam int MAX_PATTERN    = 8;
  localparam int MAX_SUBSTITUTE = 8;
  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int BURST_MAX      = (MAX_PATTERN > MAX_SUBSTITUTE) ? MAX_PATTERN : MAX_SUBSTITUTE;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 2'd0,
    REG_PATTERN_LENGTH    = 2'd1,
    REG_SUBSTITUTE_BYTES  = 2'd2,
    REG_SUBSTITUTE_LENGTH = 2'd3
  } cfg_reg_e;

  // Effective configuration, lengths already clamped.
  typedef struct packed {
    logic [MAX_PATTERN-1:0][CHAR_W-1:0]    pattern;
    logic [LEN_W-1:0]                      pattern_len;
    logic [MAX_SUBSTITUTE-1:0][CHAR_W-1:0] substitute;
    logic [LEN_W-1:0]                      substitute_len;
  } cfg_t;

  // Words caused by one input byte.
  typedef struct packed {
    logic [BURST_MAX-1:0][CHAR_W-1:0] bytes;
    logic [LEN_W-1:0]                 count;
    logic                             is_last;
    logic                             bare;
  } burst_t;

endpackage

[src/ssr_in_if.sv]
// Input channel: one source byte and its end-of-string flag.
`timescale 1ns / 1ps
interface ssr_in_if import ssr_pkg::*;;
  logic  valid;
  logic  ready;
  char_t in_char;
  logic  in_final;

  modport source (output valid, output in_char, output in_final, input ready);
  modport sink   (input valid, input in_char, input in_final, output ready);
endinterface

[src/ssr_out_if.sv]
// Output channel: one result word.
`timescale 1ns / 1ps
interface ssr_out_if import ssr_pkg::*;;
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  out_present;
  logic  run_done;
  logic  string_done;

  modport source (output valid, output out_char, output out_present, output run_done,
                  output string_done, input ready);
  modport sink   (input valid, input out_char, input out_present, input run_done,
                  input string_done, output ready);
endinterface

[src/ssr_cfg_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface ssr_cfg_if import ssr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/ssr_cfg.sv]
// Configuration registers with clamped pattern and replacement lengths.
`timescale 1ns / 1ps
module ssr_cfg import ssr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ssr_cfg_if.sink      cfg,
  output cfg_t         cfg_eff
);

  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] substitute_bytes;
  logic [LEN_W-1:0]      substitute_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_length    <= LEN_W'(1);
      substitute_bytes  <= '0;
      substitute_length <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_BYTES:     pattern_bytes     <= cfg.data;
        REG_PATTERN_LENGTH:    pattern_length    <= cfg.data[LEN_W-1:0];
        REG_SUBSTITUTE_BYTES:  substitute_bytes  <= cfg.data;
        REG_SUBSTITUTE_LENGTH: substitute_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff.pattern    = pattern_bytes;
    cfg_eff.substitute = substitute_bytes;
    if (pattern_length == '0)
      cfg_eff.pattern_len = LEN_W'(1);
    else if (pattern_length > LEN_W'(MAX_PATTERN))
      cfg_eff.pattern_len = LEN_W'(MAX_PATTERN);
    else
      cfg_eff.pattern_len = pattern_length;
    if (substitute_length > LEN_W'(MAX_SUBSTITUTE))
      cfg_eff.substitute_len = LEN_W'(MAX_SUBSTITUTE);
    else
      cfg_eff.substitute_len = substitute_length;
  end

endmodule

[src/ssr_window.sv]
// Match window: appends the byte, compares against the pattern, builds the word burst.
`timescale 1ns / 1ps
module ssr_window import ssr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  char_t  in_char,
  input  logic   in_final,
  input  cfg_t   cfg_eff,
  output burst_t burst,
  output logic   burst_valid
);

  logic [MAX_PATTERN-1:0][CHAR_W-1:0] win;
  logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_next;
  logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_in;
  logic [LEN_W-1:0]                   fill;
  logic [LEN_W-1:0]                   fill_next;
  logic [LEN_W-1:0]                   fill_in;
  logic                               hit;

  always_comb begin
    win_in  = win;
    fill_in = fill;
    if (fill < LEN_W'(MAX_PATTERN)) begin
      win_in[fill[$clog2(MAX_PATTERN)-1:0]] = in_char;
      fill_in = fill + LEN_W'(1);
    end

    hit = (fill_in == cfg_eff.pattern_len);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < cfg_eff.pattern_len && win_in[i] != cfg_eff.pattern[i])
        hit = 1'b0;
    end

    burst         = '0;
    burst.is_last = in_final;
    win_next      = win_in;
    fill_next     = fill_in;

    if (hit) begin
      burst.bytes = cfg_eff.substitute;
      burst.count = cfg_eff.substitute_len;
      fill_next   = '0;
    end else if (in_final) begin
      // flush the whole window, oldest first
      burst.bytes = win_in;
      burst.count = fill_in;
    end else if (fill_in >= cfg_eff.pattern_len) begin
      // emit the oldest byte and slide
      burst.bytes[0] = win_in[0];
      burst.count    = LEN_W'(1);
      win_next       = {CHAR_W'(0), win_in[MAX_PATTERN-1:1]};
      fill_next      = fill_in - LEN_W'(1);
    end

    if (in_final) begin
      fill_next = '0;
      if (burst.count == '0) begin
        burst.count = LEN_W'(1);
        burst.bare  = 1'b1;
      end
    end

    burst_valid = (burst.count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
      win  <= win_next;
    end
  end

endmodule

[src/ssr_emit.sv]
// Burst register and output register: drains one word per cycle while dout is not stalled.
`timescale 1ns / 1ps
module ssr_emit import ssr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  burst_t    burst,
  output logic      free,
  ssr_out_if.source dout
);

  logic                             bvalid;
  logic [BURST_MAX-1:0][CHAR_W-1:0] bbytes;
  logic [LEN_W-1:0]                 remain;
  logic                             blast;
  logic                             bbare;

  logic  ovalid;
  char_t ochar;
  logic  opresent;
  logic  orun;
  logic  ostring;

  logic out_load;
  logic take;
  logic last_word;

  assign out_load  = !ovalid || dout.ready;
  assign take      = bvalid && out_load;
  assign last_word = (remain == LEN_W'(1));
  assign free      = !bvalid || (take && last_word);

  assign dout.valid       = ovalid;
  assign dout.out_char    = ochar;
  assign dout.out_present = opresent;
  assign dout.run_done    = orun;
  assign dout.string_done = ostring;

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        bvalid <= 1'b1;
        bbytes <= burst.bytes;
        remain <= burst.count;
        blast  <= burst.is_last;
        bbare  <= burst.bare;
      end else if (take) begin
        bbytes <= {CHAR_W'(0), bbytes[BURST_MAX-1:1]};
        remain <= remain - LEN_W'(1);
        if (last_word)
          bvalid <= 1'b0;
      end

      if (out_load)
        ovalid <= bvalid;
      if (take) begin
        ochar    <= bbare ? CHAR_W'(0) : bbytes[0];
        opresent <= !bbare;
        orun     <= last_word;
        ostring  <= last_word && blast;
      end
    end
  end

endmodule

[src/stream_substring_replace.sv]
// Top level of the streaming substring replace block.
`timescale 1ns / 1ps
// Streaming leftmost, non-overlapping find-and-replace over a byte string. Each
// accepted byte enters a window as long as the pattern (1 to 8 bytes); a full
// window that equals the pattern is replaced by the replacement text (0 to 8
// bytes), otherwise its oldest byte is passed on. The byte flagged final flushes
// the window and its last word carries string_done; a bare end marker
// (out_present 0) is sent when nothing is left. With dout ready, a byte is taken
// every cycle as long as it causes at most one word; a byte that causes k words
// drains one word per cycle from the burst register, and the next byte is taken
// with the last of them, so din.ready is low while the others drain. The first
// word of a byte passes through the burst register and the output register
// before it is on dout. Write configuration only while no string is in flight.
module stream_substring_replace import ssr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ssr_cfg_if.sink   cfg,
  ssr_in_if.sink    din,
  ssr_out_if.source dout
);

  cfg_t   cfg_eff;
  burst_t burst;
  logic   burst_valid;
  logic   free;
  logic   accept;

  assign din.ready = free;
  assign accept    = din.valid && free;

  ssr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_eff (cfg_eff)
  );

  ssr_window u_window (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_char     (din.in_char),
    .in_final    (din.in_final),
    .cfg_eff     (cfg_eff),
    .burst       (burst),
    .burst_valid (burst_valid)
  );

  ssr_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .load  (accept && burst_valid),
    .burst (burst),
    .free  (free),
    .dout  (dout)
  );

endmodule

[src/ssr_checker.sv]
// Port-level checks for the substring replace block, bound to the top level.
`timescale 1ns / 1ps
`include "stream_substring_replace_assert.svh"
module ssr_checker import ssr_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  out_valid,
  input logic  out_ready,
  input char_t out_char,
  input logic  out_present,
  input logic  run_done,
  input logic  string_done
);

  `SSR_ASSERT_NOW(a_string_done_ends_run, out_valid && string_done, run_done, "string_done without run_done")
  `SSR_ASSERT_NOW(a_bare_marker_is_end, out_valid && !out_present, string_done && run_done && out_char == '0, "bare marker not an end word")
  `SSR_ASSERT_NOW(a_quiet_after_reset, $past(rst), !out_valid, "word shown right after reset")
  `SSR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(run_done), "stalled word changed")

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .out_char    (dout.out_char),
  .out_present (dout.out_present),
  .run_done    (dout.run_done),
  .string_done (dout.string_done)
);

[tb/ssr_replace_checker.sv]
// Checker for the substring replace block: predicts the output words and compares them.
`timescale 1ns / 1ps
module ssr_replace_checker import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ssr_cfg_if          cfg,
  ssr_in_if           din,
  ssr_out_if          dout,
  output int unsigned mismatches,
  output int unsigned words_owed,
  output int unsigned words_checked,
  output int unsigned strings_closed,
  output int unsigned replacements
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    char_t ch;
    logic  present;
    logic  run_end;
    logic  str_end;
  } word_t;

  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [CFG_DATA_W-1:0] sub_bytes;
  logic [LEN_W-1:0]      pat_len;
  logic [LEN_W-1:0]      sub_len;
  char_t                 window [MAX_PATTERN];
  int unsigned           fill;
  word_t                 owed_words [$];
  int unsigned           miss_cnt;
  int unsigned           word_cnt;
  int unsigned           close_cnt;
  int unsigned           hit_cnt;

  function automatic void clear_window();
    foreach (window[k]) window[k] = '0;
    fill = 0;
  endfunction

  function automatic void drop_oldest();
    int k;
    for (k = 0; k < MAX_PATTERN - 1; k++) window[k] = window[k + 1];
    window[MAX_PATTERN - 1] = '0;
    if (fill > 0) fill--;
  endfunction

  function automatic word_t data_word(char_t c);
    return '{ch: c, present: 1'b1, run_end: 1'b0, str_end: 1'b0};
  endfunction

  // Expected words for one accepted byte, appended to the owed queue.
  function automatic void predict_byte(char_t c, logic fin);
    word_t       burst [BURST_MAX];
    int unsigned plen;
    int unsigned slen;
    int unsigned n;
    int          k;
    logic        hit;
    plen = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
    slen = (sub_len > MAX_SUBSTITUTE) ? MAX_SUBSTITUTE : sub_len;
    n = 0;
    hit = 1'b0;
    if (fill < MAX_PATTERN) begin
      window[fill] = c;
      fill++;
    end
    // Compare only when the window holds exactly one pattern length.
    if (fill == plen) begin
      hit = 1'b1;
      for (k = 0; k < plen; k++)
        if (window[k] != pat_bytes[CHAR_W*k +: CHAR_W]) hit = 1'b0;
    end
    if (hit) begin
      for (k = 0; k < slen; k++) begin
        burst[n] = data_word(sub_bytes[CHAR_W*k +: CHAR_W]);
        n++;
      end
      clear_window();
      hit_cnt++;
    end else if (fin) begin
      while (fill > 0) begin
        burst[n] = data_word(window[0]);
        n++;
        drop_oldest();
      end
    end else if (fill >= plen) begin
      burst[n] = data_word(window[0]);
      n++;
      drop_oldest();
    end
    if (fin) begin
      // Nothing left to send: close the string with a bare marker.
      if (n == 0) begin
        burst[0] = '0;
        n = 1;
      end
      burst[n-1].str_end = 1'b1;
      clear_window();
    end
    if (n > 0) burst[n-1].run_end = 1'b1;
    for (k = 0; k < n; k++) owed_words = {owed_words, burst[k]};
  endfunction

  always @(posedge clk) begin : track
    word_t want;
    word_t got;
    if (rst) begin
      pat_bytes = '0;
      pat_len   = LEN_W'(1);
      sub_bytes = '0;
      sub_len   = '0;
      clear_window();
      owed_words.delete();
      miss_cnt  = 0;
      word_cnt  = 0;
      close_cnt = 0;
      hit_cnt   = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_e'(cfg.index))
          REG_PATTERN_BYTES:     pat_bytes = cfg.data;
          REG_PATTERN_LENGTH:    pat_len   = cfg.data[LEN_W-1:0];
          REG_SUBSTITUTE_BYTES:  sub_bytes = cfg.data;
          REG_SUBSTITUTE_LENGTH: sub_len   = cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
      // Words show on dout only after their byte is registered, so check before predicting.
      if (dout.valid && dout.ready) begin
        got = '{ch: dout.out_char, present: dout.out_present,
                run_end: dout.run_done, str_end: dout.string_done};
        word_cnt++;
        if (got.str_end === 1'b1) close_cnt++;
        if (owed_words.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= REPORT_LIMIT)
            $display("%0t: unexpected word %0d: char %02h present %b run_done %b string_done %b",
                     $realtime, word_cnt, got.ch, got.present, got.run_end, got.str_end);
        end else begin
          want = owed_words.pop_front();
          if (got !== want) begin
            miss_cnt++;
            if (miss_cnt <= REPORT_LIMIT) begin
              $display("%0t: word %0d mismatch", $realtime, word_cnt);
              $display("  expected char %02h present %b run_done %b string_done %b",
                       want.ch, want.present, want.run_end, want.str_end);
              $display("  actual   char %02h present %b run_done %b string_done %b",
                       got.ch, got.present, got.run_end, got.str_end);
            end
          end
        end
      end
      if (din.valid && din.ready) predict_byte(din.in_char, din.in_final);
    end
    mismatches     <= miss_cnt;
    words_owed     <= owed_words.size();
    words_checked  <= word_cnt;
    strings_closed <= close_cnt;
    replacements   <= hit_cnt;
  end

endmodule

[tb/testbench.sv]
// Top of the substring replace testbench: clock, reset, stimulus, output pacing and verdict.
`timescale 1ns / 1ps
module testbench;
  import ssr_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 40;

  logic        clk;
  logic        rst = 1'b1;
  bit          steady = 1'b0;
  bit          hold_output = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatches;
  int unsigned words_owed;
  int unsigned words_checked;
  int unsigned strings_closed;
  int unsigned replacements;

  ssr_cfg_if cfg ();
  ssr_in_if  din ();
  ssr_out_if dout ();

  stream_substring_replace dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .din  (din),
    .dout (dout)
  );

  ssr_replace_checker replace_check (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .din            (din),
    .dout           (dout),
    .mismatches     (mismatches),
    .words_owed     (words_owed),
    .words_checked  (words_checked),
    .strings_closed (strings_closed),
    .replacements   (replacements)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk) begin
    if (rst || (cfg.valid && cfg.ready) || (din.valid && din.ready) ||
        (dout.valid && dout.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : output_pacing
    int unsigned stall_left;
    stall_left = 0;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        dout.ready <= 1'b0;
      end else if (stall_left > 0) begin
        dout.ready <= 1'b0;
        stall_left--;
      end else if (hold_output) begin
        // Long hold: let the block back up into its input.
        hold_output = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        dout.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          dout.ready <= 1'b0;
          stall_left--;
        end else begin
          dout.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_byte(char_t c, bit fin);
    int unsigned gap;
    din.valid    <= 1'b1;
    din.in_char  <= c;
    din.in_final <= fin;
    do @(posedge clk); while (!din.ready);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(string s, bit close);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k], close && (k == s.len() - 1));
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic load_config(logic [CFG_DATA_W-1:0] pattern, logic [LEN_W-1:0] plen,
                             logic [CFG_DATA_W-1:0] substitute, logic [LEN_W-1:0] slen);
    write_reg(REG_PATTERN_BYTES, pattern);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
    write_reg(REG_SUBSTITUTE_BYTES, substitute);
    write_reg(REG_SUBSTITUTE_LENGTH, CFG_DATA_W'(slen));
  endtask

  // Drop the input, hold until every owed word is back, then let the burst drain settle.
  task automatic wait_idle();
    din.valid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] pattern;
    logic [CFG_DATA_W-1:0] substitute;
    logic [LEN_W-1:0]      plen;
    logic [LEN_W-1:0]      slen;
    int unsigned           eff_len;
    int unsigned           string_left;
    int unsigned           sent;
    int unsigned           roll;
    int unsigned           cut;
    int                    phase;
    int                    k;
    char_t                 alpha [3];
    char_t                 text [$];
    char_t                 c;

    cfg.valid    <= 1'b0;
    cfg.index    <= REG_PATTERN_BYTES;
    cfg.data     <= '0;
    din.valid    <= 1'b0;
    din.in_char  <= '0;
    din.in_final <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one-byte pattern 00, empty replacement.
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);

    // Zero pattern length acts as one; oversized replacement length clamps to eight.
    wait_idle();
    load_config(64'hFFFF_FFFF_FFFF_FF80, 4'd0, 64'hFF01_2345_6789_AB00, 4'd15);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);

    // Oversized pattern length clamps to eight; full window flushed on the last byte.
    wait_idle();
    load_config(64'h4847_4645_4443_4241, 4'd15, 64'h0, 4'd3);
    send_text("ABCDEFGZ", 1'b1);
    send_text("ABCDE", 1'b0);
    // Shorten the pattern while the window still holds five bytes.
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    send_text("FG", 1'b1);

    string_left = $urandom_range(24, 1);
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      foreach (alpha[j]) alpha[j] = char_t'($urandom);
      for (k = 0; k < MAX_PATTERN; k++)
        pattern[CHAR_W*k +: CHAR_W] = alpha[$urandom_range(2)];
      substitute = {$urandom, $urandom};
      if (phase == 5) substitute = '1;
      if (phase == 6) begin
        pattern    = '1;
        substitute = '0;
      end
      roll = $urandom_range(9);
      if (roll == 0)      plen = '0;
      else if (roll == 1) plen = LEN_W'($urandom_range(15, 9));
      else                plen = LEN_W'($urandom_range(8, 1));
      slen = LEN_W'($urandom_range(15));
      eff_len = (plen == 0) ? 1 : (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      load_config(pattern, plen, substitute, slen);

      steady = (phase % 4 == 1) || (phase == 3);
      if (phase == 3) hold_output = 1'b1;
      text.delete();
      for (sent = 0; sent < PHASE_ITEMS; sent++) begin
        // Build the string from whole patterns, pattern prefixes and noise.
        if (text.size() == 0) begin
          roll = $urandom_range(99);
          if (roll < 55)      cut = eff_len;
          else if (roll < 75) cut = $urandom_range(eff_len, 1);
          else                cut = 0;
          for (k = 0; k < cut; k++) text = {text, pattern[CHAR_W*k +: CHAR_W]};
          if (cut == 0)
            repeat ($urandom_range(3, 1))
              text = {text, roll[0] ? char_t'($urandom) : alpha[$urandom_range(2)]};
        end
        c = text.pop_front();
        string_left--;
        send_byte(c, string_left == 0);
        if (string_left == 0)
          string_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
      end
      steady = 1'b0;
    end

    din.valid <= 1'b0;
    wait_idle();
    $display("Covered %0d input bytes over %0d random settings plus directed edge cases;",
             bytes_sent, PHASES);
    $display("checked %0d words, %0d strings closed, %0d pattern hits.",
             words_checked, strings_closed, replacements);
    if (mismatches == 0 && words_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ssr_pkg.sv
src/ssr_in_if.sv
src/ssr_out_if.sv
src/ssr_cfg_if.sv
src/ssr_cfg.sv
src/ssr_window.sv
src/ssr_emit.sv
src/stream_substring_replace.sv
src/ssr_checker.sv
tb/ssr_replace_checker.sv
tb/testbench.sv
